@@ rtl/core/gif_lzw_decoder_unit_defines.svh @@
// Assertion macros for the GIF LZW decoder unit.
// Used by the RTL files that carry concurrent assertions.
`ifndef GIF_LZW_DECODER_UNIT_DEFINES_SVH
`define GIF_LZW_DECODER_UNIT_DEFINES_SVH

// assert that a condition implies a consequence in the same cycle
`define GLD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// assert that a condition implies a consequence in the next cycle
`define GLD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/gld_pkg.sv @@
// Shared constants and types for the GIF LZW decoder unit.
// No dependencies.
package gld_pkg;
    localparam int TABLE_ENTRIES = 4096;
    localparam int ADDR_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = ADDR_W + 1;

    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_PULL = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    localparam logic [2:0] ST_PIXEL = 3'd0;
    localparam logic [2:0] ST_ACCEPT = 3'd1;
    localparam logic [2:0] ST_REFUSE = 3'd2;
    localparam logic [2:0] ST_NEED = 3'd3;
    localparam logic [2:0] ST_END = 3'd4;

    // dictionary memory request
    typedef struct packed {
        logic              wr;
        logic [ADDR_W-1:0] waddr;
        logic [ADDR_W-1:0] wprefix;
        logic [7:0]        wsuffix;
        logic [ADDR_W-1:0] raddr;
    } dict_req_t;
endpackage

@@ rtl/core/gif_lzw_decoder_unit.sv @@
// GIF LZW decoder unit: push stream bytes, pull pixels, one result per transaction.
// The input stalls from acceptance until the result has been taken, so transactions
// run one at a time. A push, a restart or an unused operation passes through S_OUT
// before its result is presented, and a pull that pops a stacked pixel through S_POP
// and S_OUT. A pull that must decode examines each code in S_CODE (the final check
// that finds too few bits included) and pushes each pixel in S_WALK while walking
// the dictionary chain, each chain step being one registered read of the dictionary
// memory, then goes to S_POP to pop and S_OUT to present a pixel, or to S_OUT to
// present a status. A result is held in the output register while out_stall is high;
// the next transaction is accepted at the earliest in the cycle after it is taken.
// Depends on gld_pkg, gld_dict_ram, gld_stack_ram and the defines.
`include "gif_lzw_decoder_unit_defines.svh"
module gif_lzw_decoder_unit
    import gld_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       valid,
    output logic       stall,
    input  logic [1:0] operation,
    input  logic [7:0] data_byte,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [3:0] cfg_data,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] status,
    output logic [7:0] pixel
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CODE = 3'd1;
    localparam logic [2:0] S_WALK = 3'd2;
    localparam logic [2:0] S_POP  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [3:0]        root_cfg_reg, root_cfg_next;
    logic [3:0]        root_reg, root_next;
    logic [3:0]        width_reg, width_next;
    logic [CNT_W-1:0]  slot_reg, slot_next;
    logic [ADDR_W-1:0] prev_reg, prev_next;
    logic              prev_ok_reg, prev_ok_next;
    logic [7:0]        first_reg, first_next;
    logic [CNT_W-1:0]  sp_reg, sp_next;
    logic [19:0]       buf_reg, buf_next;
    logic [4:0]        bits_reg, bits_next;
    logic [7:0]        blk_reg, blk_next;
    logic              ended_reg, ended_next;
    logic [ADDR_W-1:0] chain_reg, chain_next;
    logic [ADDR_W-1:0] code_reg, code_next;
    logic              ovalid_reg, ovalid_next;
    logic [2:0]        ostat_reg, ostat_next;
    logic [7:0]        opix_reg, opix_next;

    dict_req_t         dreq;
    logic [ADDR_W-1:0] d_prefix;
    logic [7:0]        d_suffix;
    logic              s_wr;
    logic [ADDR_W-1:0] s_waddr, s_raddr;
    logic [7:0]        s_wdata, s_rdata;

    logic [CNT_W-1:0]  clear_code;
    logic [12:0]       mask;
    logic [12:0]       code;
    logic [3:0]        root_clamped;
    logic [CNT_W-1:0]  slot_inc;

    gld_dict_ram u_dict (.clk(clk), .req(dreq), .rprefix(d_prefix), .rsuffix(d_suffix));
    gld_stack_ram u_stack (.clk(clk), .wr(s_wr), .waddr(s_waddr), .wdata(s_wdata),
                           .raddr(s_raddr), .rdata(s_rdata));

    assign stall = (state_reg != S_IDLE) || ovalid_reg;
    assign cfg_ready = 1'b1;
    assign out_valid = ovalid_reg;
    assign status = ostat_reg;
    assign pixel = opix_reg;

    always_comb
    begin
        clear_code = CNT_W'(1) << root_reg;
        mask = (13'd1 << width_reg) - 13'd1;
        code = 13'(buf_reg) & mask;
        root_clamped = (root_cfg_reg < 4'd2) ? 4'd2 :
                       (root_cfg_reg > 4'd8) ? 4'd8 : root_cfg_reg;
        slot_inc = slot_reg + CNT_W'(1);
    end

    always_comb
    begin
        state_next = state_reg;
        root_cfg_next = (cfg_valid) ? cfg_data : root_cfg_reg;
        root_next = root_reg;
        width_next = width_reg;
        slot_next = slot_reg;
        prev_next = prev_reg;
        prev_ok_next = prev_ok_reg;
        first_next = first_reg;
        sp_next = sp_reg;
        buf_next = buf_reg;
        bits_next = bits_reg;
        blk_next = blk_reg;
        ended_next = ended_reg;
        chain_next = chain_reg;
        code_next = code_reg;
        ovalid_next = ovalid_reg && out_stall;
        ostat_next = ostat_reg;
        opix_next = opix_reg;
        dreq = '0;
        s_wr = 1'b0;
        s_waddr = sp_reg[ADDR_W-1:0];
        s_wdata = first_reg;
        s_raddr = sp_reg[ADDR_W-1:0] - ADDR_W'(1);

        case (state_reg)
            S_IDLE:
            begin
                if (valid && !stall)
                begin
                    state_next = S_OUT;
                    ostat_next = ST_REFUSE;
                    opix_next = 8'd0;
                    case (operation)
                        OP_PUSH:
                        begin
                            if (ended_reg)
                            begin
                                ostat_next = ST_END;
                            end
                            else if (blk_reg == 8'd0)
                            begin
                                blk_next = data_byte;
                                ostat_next = ST_ACCEPT;
                            end
                            else if ({1'b0, bits_reg} < {2'b0, width_reg})
                            begin
                                buf_next = buf_reg | (20'(data_byte) << bits_reg);
                                bits_next = bits_reg + 5'd8;
                                blk_next = blk_reg - 8'd1;
                                ostat_next = ST_ACCEPT;
                            end
                        end
                        OP_PULL:
                        begin
                            state_next = (sp_reg != '0) ? S_POP : S_CODE;
                        end
                        OP_RESTART:
                        begin
                            root_next = root_clamped;
                            width_next = root_clamped + 4'd1;
                            slot_next = (CNT_W'(1) << root_clamped) + CNT_W'(2);
                            prev_ok_next = 1'b0;
                            prev_next = '0;
                            sp_next = '0;
                            buf_next = '0;
                            bits_next = '0;
                            first_next = '0;
                            blk_next = '0;
                            ended_next = 1'b0;
                            ostat_next = ST_ACCEPT;
                        end
                        default:
                        begin
                            ostat_next = ST_REFUSE;
                        end
                    endcase
                end
            end
            S_POP:
            begin
                // read issued last cycle at sp-1 is not ready; issue now, emit next
                sp_next = sp_reg - CNT_W'(1);
                state_next = S_OUT;
                ostat_next = ST_PIXEL;
                code_next = '1;
            end
            S_CODE:
            begin
                if (ended_reg)
                begin
                    ostat_next = ST_END;
                    state_next = S_OUT;
                end
                else if (bits_reg < {1'b0, width_reg})
                begin
                    ostat_next = ST_NEED;
                    state_next = S_OUT;
                end
                else
                begin
                    buf_next = buf_reg >> width_reg;
                    bits_next = bits_reg - {1'b0, width_reg};
                    code_next = code[ADDR_W-1:0];
                    if ({1'b0, code} > 14'(slot_reg) || {1'b0, code} == 14'(clear_code) + 14'd1)
                    begin
                        ended_next = 1'b1;
                        ostat_next = ST_END;
                        state_next = S_OUT;
                    end
                    else if (13'(code) == 13'(clear_code))
                    begin
                        width_next = root_reg + 4'd1;
                        slot_next = clear_code + CNT_W'(2);
                        prev_ok_next = 1'b0;
                        prev_next = '0;
                    end
                    else if (!prev_ok_reg)
                    begin
                        if (13'(code) >= 13'(clear_code))
                        begin
                            ended_next = 1'b1;
                            ostat_next = ST_END;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            s_wr = 1'b1;
                            s_wdata = code[7:0];
                            sp_next = sp_reg + CNT_W'(1);
                            prev_next = code[ADDR_W-1:0];
                            prev_ok_next = 1'b1;
                            first_next = code[7:0];
                            state_next = S_POP;
                        end
                    end
                    else
                    begin
                        chain_next = code[ADDR_W-1:0];
                        if (13'(code) == 13'(slot_reg))
                        begin
                            s_wr = 1'b1;
                            s_wdata = first_reg;
                            sp_next = sp_reg + CNT_W'(1);
                            chain_next = prev_reg;
                        end
                        dreq.raddr = chain_next;
                        state_next = S_WALK;
                    end
                end
            end
            S_WALK:
            begin
                // dictionary data for chain_reg arrives this cycle
                if (CNT_W'(chain_reg) > clear_code)
                begin
                    if (sp_reg < CNT_W'(TABLE_ENTRIES))
                    begin
                        s_wr = 1'b1;
                        s_wdata = d_suffix;
                        sp_next = sp_reg + CNT_W'(1);
                    end
                    chain_next = d_prefix;
                    dreq.raddr = d_prefix;
                end
                else
                begin
                    first_next = chain_reg[7:0];
                    if (slot_reg >= CNT_W'(TABLE_ENTRIES))
                    begin
                        ended_next = 1'b1;
                        ostat_next = ST_END;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        if (sp_reg < CNT_W'(TABLE_ENTRIES))
                        begin
                            s_wr = 1'b1;
                            s_wdata = chain_reg[7:0];
                            sp_next = sp_reg + CNT_W'(1);
                        end
                        dreq.wr = 1'b1;
                        dreq.waddr = slot_reg[ADDR_W-1:0];
                        dreq.wprefix = prev_reg;
                        dreq.wsuffix = chain_reg[7:0];
                        slot_next = slot_inc;
                        if ((13'(slot_inc) & mask) == 13'd0 && slot_inc < CNT_W'(TABLE_ENTRIES))
                        begin
                            width_next = width_reg + 4'd1;
                        end
                        prev_next = code_reg;
                        state_next = S_POP;
                    end
                end
            end
            S_OUT:
            begin
                ovalid_next = 1'b1;
                if (ostat_reg == ST_PIXEL)
                begin
                    opix_next = s_rdata;
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            root_cfg_reg <= 4'd8;
            root_reg <= 4'd8;
            width_reg <= 4'd9;
            slot_reg <= CNT_W'(258);
            prev_reg <= '0;
            prev_ok_reg <= 1'b0;
            first_reg <= '0;
            sp_reg <= '0;
            buf_reg <= '0;
            bits_reg <= '0;
            blk_reg <= '0;
            ended_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            root_cfg_reg <= root_cfg_next;
            root_reg <= root_next;
            width_reg <= width_next;
            slot_reg <= slot_next;
            prev_reg <= prev_next;
            prev_ok_reg <= prev_ok_next;
            first_reg <= first_next;
            sp_reg <= sp_next;
            buf_reg <= buf_next;
            bits_reg <= bits_next;
            blk_reg <= blk_next;
            ended_reg <= ended_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chain_reg <= chain_next;
        code_reg <= code_next;
        ostat_reg <= ostat_next;
        opix_reg <= opix_next;
    end

    `GLD_ASSERT_IMP(a_stall_busy, clk, rst_n, state_reg != S_IDLE, stall, "busy but not stalling")
    `GLD_ASSERT_IMP(a_width_max, clk, rst_n, 1'b1, width_reg <= 4'd12, "code width above 12")
    `GLD_ASSERT_NEXT(a_out_from_idle, clk, rst_n, state_reg == S_OUT, out_valid, "result lost")
    `GLD_ASSERT_IMP(a_sp_range, clk, rst_n, 1'b1, sp_reg <= CNT_W'(TABLE_ENTRIES),
                    "stack count out of range")
endmodule

@@ rtl/core/gld_dict_ram.sv @@
// Prefix and suffix dictionary memory of the GIF LZW decoder.
// Depends on gld_pkg.
module gld_dict_ram
    import gld_pkg::*;
(
    input  logic              clk,
    input  dict_req_t         req,
    output logic [ADDR_W-1:0] rprefix,
    output logic [7:0]        rsuffix
);
    logic [ADDR_W+7:0] mem [TABLE_ENTRIES];

    always_ff @(posedge clk)
    begin
        if (req.wr)
        begin
            mem[req.waddr] <= {req.wprefix, req.wsuffix};
        end
        {rprefix, rsuffix} <= mem[req.raddr];
    end
endmodule

@@ rtl/core/gld_stack_ram.sv @@
// Pixel stack memory of the GIF LZW decoder.
// Depends on gld_pkg.
module gld_stack_ram
    import gld_pkg::*;
(
    input  logic              clk,
    input  logic              wr,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [7:0]        wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [7:0]        rdata
);
    logic [7:0] mem [TABLE_ENTRIES];

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
